// ===== design/hdq7_pkg.sv =====
// Shared types and constants for the Haar DWT Q7 stage.
// No dependencies; every design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hdq7_pkg;

   localparam int SampleW = 8;
   localparam int CoefW   = 8;
   localparam int TermW   = 10;
   localparam int ProdW   = TermW + 8;
   localparam int CoefShift = 7;

   localparam logic [7:0] HAAR_WEIGHT = 8'd91;

   localparam int ModeW = 3;
   localparam logic [ModeW-1:0] EDGE_CONSTANT      = 3'd0;
   localparam logic [ModeW-1:0] EDGE_SYMMETRIC     = 3'd1;
   localparam logic [ModeW-1:0] EDGE_REFLECT       = 3'd2;
   localparam logic [ModeW-1:0] EDGE_ANTISYMMETRIC = 3'd3;
   localparam logic [ModeW-1:0] EDGE_ANTIREFLECT   = 3'd4;
   localparam logic [ModeW-1:0] EDGE_PERIODIC      = 3'd5;
   localparam logic [ModeW-1:0] EDGE_ZERO          = 3'd6;
   localparam logic [ModeW-1:0] EDGE_MODE_RESET    = EDGE_ZERO;

   localparam int CsrAddrW = 3;
   localparam logic REG_EDGE_MODE = 1'b0;

   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   typedef struct packed {
      logic signed [TermW-1:0] lo_term;
      logic signed [TermW-1:0] hi_term;
      logic                    final_flag;
   } op_type;

endpackage

`default_nettype wire

// ===== design/hdq7_front.sv =====
// Front end: edge-mode register, sample pairing and edge-extension decode.
// Depends on hdq7_pkg; pushes one op_type per result into the queue.
`timescale 1ns / 1ps
`default_nettype none

module hdq7_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,   // [7:0] sample
   input  wire logic                               req_tlast,   // is_last
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [hdq7_pkg::CsrAddrW-1:0]      csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready,
   output logic                                    push_valid,
   input  wire logic                               push_ready,
   output hdq7_pkg::op_type                        push_op
);

   logic [hdq7_pkg::ModeW-1:0]          mode_ff, mode_in;
   logic signed [hdq7_pkg::SampleW-1:0] held_ff, held_in;
   logic signed [hdq7_pkg::SampleW-1:0] prev_ff, prev_in;
   logic                                odd_ff, odd_in;
   logic                                accept;
   logic                                csr_write;
   logic                                csr_hit;
   logic signed [hdq7_pkg::TermW-1:0]   x_ext, p_ext, a_ext;
   logic signed [hdq7_pkg::TermW-1:0]   edge_lo, edge_hi;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == hdq7_pkg::REG_EDGE_MODE);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit;
   assign csr_prdata = csr_hit ? {29'd0, mode_ff} : 32'd0;

   assign mode_in = csr_write ? csr_pwdata[hdq7_pkg::ModeW-1:0] : mode_ff;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & req_tready;

   assign x_ext = {{(hdq7_pkg::TermW-hdq7_pkg::SampleW){req_tdata[7]}}, req_tdata};
   assign p_ext = {{(hdq7_pkg::TermW-hdq7_pkg::SampleW){prev_ff[7]}}, prev_ff};
   assign a_ext = {{(hdq7_pkg::TermW-hdq7_pkg::SampleW){held_ff[7]}}, held_ff};

   always_comb begin
      unique case (mode_ff) inside
         hdq7_pkg::EDGE_CONSTANT, hdq7_pkg::EDGE_SYMMETRIC: begin
            edge_lo = x_ext + x_ext;
            edge_hi = '0;
         end
         hdq7_pkg::EDGE_REFLECT: begin
            edge_lo = x_ext + p_ext;
            edge_hi = x_ext - p_ext;
         end
         hdq7_pkg::EDGE_ANTISYMMETRIC: begin
            edge_lo = '0;
            edge_hi = x_ext + x_ext;
         end
         hdq7_pkg::EDGE_ANTIREFLECT: begin
            edge_lo = x_ext + x_ext + x_ext - p_ext;
            edge_hi = p_ext - x_ext;
         end
         default: begin
            edge_lo = x_ext;
            edge_hi = x_ext;
         end
      endcase
   end

   always_comb begin
      held_in    = held_ff;
      prev_in    = prev_ff;
      odd_in     = odd_ff;
      push_valid = 1'b0;
      push_op.lo_term    = a_ext + x_ext;
      push_op.hi_term    = a_ext - x_ext;
      push_op.final_flag = req_tlast;
      if (odd_ff) begin
         push_valid = req_tvalid;
         if (accept) begin
            odd_in = 1'b0;
            if (req_tlast) begin
               held_in = '0;
               prev_in = '0;
            end else begin
               prev_in = req_tdata;
            end
         end
      end else if (req_tlast) begin
         push_valid         = req_tvalid;
         push_op.lo_term    = edge_lo;
         push_op.hi_term    = edge_hi;
         push_op.final_flag = 1'b1;
         if (accept) begin
            held_in = '0;
            prev_in = '0;
         end
      end else if (accept) begin
         held_in = req_tdata;
         odd_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hdq7_pkg::EDGE_MODE_RESET;
         held_ff <= '0;
         prev_ff <= '0;
         odd_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         prev_ff <= prev_in;
         odd_ff  <= odd_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/hdq7_queue.sv =====
// Two-entry queue of pending coefficient ops between front and back end.
// Depends on hdq7_pkg for op_type and depth constants.
`timescale 1ns / 1ps
`default_nettype none

module hdq7_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire hdq7_pkg::op_type in_op,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output hdq7_pkg::op_type      out_op
);

   hdq7_pkg::op_type                   mem_ff [hdq7_pkg::QueueDepth];
   logic [hdq7_pkg::QueuePtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [hdq7_pkg::QueueCntW-1:0]     count_ff, count_in;
   logic                               push, pop;

   assign in_ready  = (count_ff != hdq7_pkg::QueueCntW'(hdq7_pkg::QueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_op    = mem_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      count_in = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/hdq7_back.sv =====
// Back end: weight the queued terms by 91, scale by 2^-7, register the result.
// Depends on hdq7_pkg; drives the result channel.
`timescale 1ns / 1ps
`default_nettype none

module hdq7_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_valid,
   output logic                  op_ready,
   input  wire hdq7_pkg::op_type op,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [15:0]           rsp_tdata,   // [7:0] approx, [15:8] detail
   output logic                  rsp_tlast    // final_out
);

   logic                                 valid_ff;
   logic [15:0]                          data_ff, data_in;
   logic                                 last_ff;
   logic                                 advance;
   logic signed [hdq7_pkg::ProdW-1:0]    lo_ext, hi_ext, weight;
   logic signed [hdq7_pkg::ProdW-1:0]    lo_prod, hi_prod;

   assign advance  = ~valid_ff | rsp_tready;
   assign op_ready = advance;

   assign weight = $signed({{(hdq7_pkg::ProdW-8){1'b0}}, hdq7_pkg::HAAR_WEIGHT});
   assign lo_ext = {{(hdq7_pkg::ProdW-hdq7_pkg::TermW){op.lo_term[hdq7_pkg::TermW-1]}},
                    op.lo_term};
   assign hi_ext = {{(hdq7_pkg::ProdW-hdq7_pkg::TermW){op.hi_term[hdq7_pkg::TermW-1]}},
                    op.hi_term};
   assign lo_prod = lo_ext * weight;
   assign hi_prod = hi_ext * weight;

   assign data_in = {hi_prod[hdq7_pkg::CoefShift +: hdq7_pkg::CoefW],
                     lo_prod[hdq7_pkg::CoefShift +: hdq7_pkg::CoefW]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance & op_valid) begin
         data_ff <= data_in;
         last_ff <= op.final_flag;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== design/haar_dwt_q7_stage.sv =====
// Top level of the one-level Haar DWT stage on signed Q7 samples.
// Depends on hdq7_pkg, hdq7_front, hdq7_queue and hdq7_back.
//
// Usage:
//   req channel: one signed Q7 sample per item in req_tdata, req_tlast
//   marks the final sample of a signal. Samples pair up (a, b); each pair
//   gives approx = 91(a+b) >> 7 and detail = 91(a-b) >> 7, wrapped to 8 bits.
//   A signal ending on an unpaired sample gives one extra result from the
//   edge mode in csr register 0 (byte address 0, reset value 6 = zero).
//   rsp channel: approx in rsp_tdata[7:0], detail in [15:8], rsp_tlast on
//   the last coefficient pair of a signal.
//   Path: the item that closes a result is written into the queue, then
//   popped into the output register that drives rsp.
//   Throughput: one sample per cycle while the queue has room, set by the
//   single constant-multiply stage in the back end.
//   Stalls: a two-entry queue and the output register absorb up to three
//   results while rsp_tready is low; req_tready drops once the queue fills.
//   Reset: synchronous; clears pairing state, queue and output valid and
//   returns edge_mode to 6.
//   Write csr only while no results are pending.
`timescale 1ns / 1ps
`default_nettype none

module haar_dwt_q7_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] sample
   input  wire logic                          req_tlast,   // is_last
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [7:0] approx, [15:8] detail
   output logic                               rsp_tlast,   // final_out
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [hdq7_pkg::CsrAddrW-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic             push_valid, push_ready;
   hdq7_pkg::op_type push_op;
   logic             pop_valid, pop_ready;
   hdq7_pkg::op_type pop_op;

   hdq7_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_op     (push_op)
   );

   hdq7_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_op     (push_op),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_op    (pop_op)
   );

   hdq7_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (pop_valid),
      .op_ready   (pop_ready),
      .op         (pop_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== design/hdq7_checker.sv =====
// Port-level checks for haar_dwt_q7_stage, attached by bind.
// Depends on hdq7_pkg for the csr address width.
`timescale 1ns / 1ps
`default_nettype none

module hdq7_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [15:0]                   rsp_tdata,
   input wire logic                          csr_psel,
   input wire logic                          csr_penable,
   input wire logic                          csr_pwrite,
   input wire logic                          csr_pready,
   input wire logic [hdq7_pkg::CsrAddrW-1:0] csr_paddr,
   input wire logic [31:0]                   csr_pwdata,
   input wire logic [31:0]                   csr_prdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching accepted item");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]
      |=> csr_prdata[2:0] == $past(csr_pwdata[2:0]))
      else $error("edge_mode readback mismatch");

endmodule

bind haar_dwt_q7_stage hdq7_checker u_hdq7_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_pready  (csr_pready),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire
